### design/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
package spq_pkg;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_PEEK   = 2'd2
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SORT_ORDER = 2'd0;
  localparam logic [1:0] CFG_CAPACITY   = 2'd1;

  localparam int CfgDataWidth = 5;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;    // accepted insert that is not refused
    logic rem;    // accepted remove that is not refused
    logic order;  // 0 largest first, 1 smallest first
  } cell_ctrl_t;

endpackage

### design/spq_cell.sv
// One storage cell of the sorted queue row.
// Depends on spq_pkg for the cell command struct.
module spq_cell import spq_pkg::*; #(
  parameter int KEY_W = 16,
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [KEY_W-1:0] new_key_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic             found_i,
  output logic             found_o,
  output logic [KEY_W-1:0] key_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic             in_use, at_end, beats, hit;

  assign in_use = count_i > CNT_W'(INDEX);
  assign at_end = count_i == CNT_W'(INDEX);
  assign beats  = ctrl_i.order ? (new_key_i < key_q) : (new_key_i > key_q);
  // This cell is the insert point if it is the first stored entry beaten,
  // or the first free slot when nothing earlier was beaten.
  assign hit     = (in_use && beats) || at_end;
  assign found_o = found_i || hit;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins) begin
      if (found_i) begin
        key_d = left_key_i;
      end else if (hit) begin
        key_d = new_key_i;
      end
    end else if (ctrl_i.rem) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

### design/sorted_priority_queue.sv
// Sorted priority queue built as a row of shifting key cells.
// Output: a result word is loaded into the output register at the edge that accepts its request.
// Throughput: one request word per cycle while results are taken; every cell compares against the
// new key in the same cycle and the first-beaten flag ripples along the row, which sets the cycle time.
// Reset: count, sort order (largest first), capacity (16) and the output valid flag are cleared;
// the key cells and the result payload are not reset, and keys are only read below the count.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [CfgDataWidth-1:0]      cfg_data_i,
  // Request channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic [KEY_WIDTH-1:0]         key_in_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [KEY_WIDTH-1:0]         key_out_o,
  output logic [1:0]                   status_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  // Width wide enough to compare the count against the capacity register.
  localparam int CMP_W = (CNT_W > CfgDataWidth) ? CNT_W : CfgDataWidth;

  // Configuration registers.
  logic                    order_q;
  logic [CfgDataWidth-1:0] cap_q;

  // Queue state and output register.
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  logic [KEY_WIDTH-1:0] key_out_q, key_out_d;
  status_e              status_q, status_d;
  logic [CNT_W-1:0]     count_out_q;

  logic       accept;
  logic       full, empty;
  logic [CMP_W-1:0] cap_eff, count_ext;
  cell_ctrl_t ctrl;

  logic [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic                 found [DEPTH+1];

  // The output register frees itself when its word is taken, so a new request
  // can be accepted in the same cycle a finished result leaves.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // A capacity of zero behaves as one; anything above the built depth saturates.
  always_comb begin
    cap_eff = CMP_W'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end
  end

  assign count_ext = CMP_W'(count_q);
  assign full      = count_ext >= cap_eff;
  assign empty     = count_q == '0;

  // Decode the request into the row command and the result word.
  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    ctrl.order = order_q;
    count_d    = count_q;
    key_out_d  = '0;
    status_d   = ST_OK;
    if (accept) begin
      case (req_e'(req_type_i))
        REQ_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.rem  = 1'b1;
            key_out_d = cell_key[0];
            count_d   = count_q - CNT_W'(1);
          end
        end
        REQ_PEEK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            key_out_d = cell_key[0];
          end
        end
        default: begin
          // The unused request code leaves the queue alone and reports ok.
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q     <= 1'b0;
      cap_q       <= CfgDataWidth'(16);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SORT_ORDER: order_q <= cfg_data_i[0];
          CFG_CAPACITY:   cap_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload is loaded only when a request is accepted.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_out_q   <= key_out_d;
      status_q    <= status_d;
      count_out_q <= count_d;
    end
  end

  // The cell row. Each cell sees its neighbors' keys: an insert shifts
  // entries behind the insert point one step back, a remove shifts all
  // entries one step forward. The first-beaten flag runs from the front.
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_key, right_key;

    if (i == 0) begin : g_first
      assign left_key = cell_key[i];
    end else begin : g_mid_l
      assign left_key = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_mid_r
      assign right_key = cell_key[i+1];
    end

    spq_cell #(
      .KEY_W (KEY_WIDTH),
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .new_key_i   (key_in_i),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .found_i     (found[i]),
      .found_o     (found[i+1]),
      .key_o       (cell_key[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign key_out_o   = key_out_q;
  assign status_o    = status_q;
  assign count_o     = count_out_q;

endmodule

### tb/sorted_priority_queue_test.sv
// Self-checking testbench for sorted_priority_queue: directed and random request words
// checked against a mirrored model of the sorted queue. Depends on spq_pkg and the block.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int Depth = 16;
  localparam int KeyWidth = 16;
  localparam int CountWidth = $clog2(Depth + 1);
  // Generous bound on the run length, well above what a slow correct run needs.
  localparam int CycleLimit = 400000;
  // Request code outside the defined set; the block must leave the queue alone.
  localparam logic [1:0] ReqUnused = 2'd3;

  typedef struct {
    logic [KeyWidth-1:0]   key;
    status_e               status;
    logic [CountWidth-1:0] count;
  } queue_result_t;

  // Shapes of the random request bursts.
  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED,
    BURST_NOISE
  } burst_e;

  // Mirror of the queue contents and registers. Every accepted request word is
  // applied here at once and the answer the block owes is queued for checking.
  class SortedQueueMirror;
    logic [KeyWidth-1:0] slots [Depth];
    int                  held;
    bit                  smallest_first;
    int                  capacity;
    queue_result_t       owed_results [$];
    bit                  failed;

    function new();
      held = 0;
      smallest_first = 1'b0;
      capacity = Depth;
      failed = 1'b0;
    endfunction

    function void write_reg(logic [1:0] index, logic [CfgDataWidth-1:0] data);
      if (index == CFG_SORT_ORDER) begin
        smallest_first = data[0];
      end else if (index == CFG_CAPACITY) begin
        capacity = data;
      end
    endfunction

    // A zero capacity acts as one, and anything above the depth as the depth.
    function int usable_slots();
      int limit;
      limit = capacity;
      if (limit == 0) begin
        limit = 1;
      end
      if (limit > Depth) begin
        limit = Depth;
      end
      return limit;
    endfunction

    function bit outranks(logic [KeyWidth-1:0] a, logic [KeyWidth-1:0] b);
      return smallest_first ? (a < b) : (a > b);
    endfunction

    function void note_request(logic [1:0] req, logic [KeyWidth-1:0] key);
      queue_result_t owed;
      int            pos;
      owed.key = '0;
      owed.status = ST_OK;
      case (req)
        REQ_INSERT: begin
          if (held >= usable_slots()) begin
            owed.status = ST_FULL;
          end else begin
            // Stop at the first stored key that the new one strictly beats,
            // so equal keys stay in arrival order.
            pos = 0;
            while (pos < held && !outranks(key, slots[pos])) begin
              pos++;
            end
            for (int i = held; i > pos; i--) begin
              slots[i] = slots[i-1];
            end
            slots[pos] = key;
            held++;
          end
        end
        REQ_REMOVE, REQ_PEEK: begin
          if (held == 0) begin
            owed.status = ST_EMPTY;
          end else begin
            owed.key = slots[0];
            if (req == REQ_REMOVE) begin
              for (int i = 0; i + 1 < held; i++) begin
                slots[i] = slots[i+1];
              end
              held--;
            end
          end
        end
        default: begin
        end
      endcase
      owed.count = CountWidth'(held);
      owed_results.push_back(owed);
    endfunction

    function void check_result(logic [KeyWidth-1:0] key, logic [1:0] status,
                               logic [CountWidth-1:0] count);
      queue_result_t owed;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result word: key_out %h status %0d count %0d",
                 $time, key, status, count);
        failed = 1'b1;
        return;
      end
      owed = owed_results.pop_front();
      if (key !== owed.key) begin
        $display("%0t: key_out mismatch: expected %h, actual %h", $time, owed.key, key);
        failed = 1'b1;
      end
      if (status !== owed.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, owed.status, status);
        failed = 1'b1;
      end
      if (count !== owed.count) begin
        $display("%0t: count mismatch: expected %0d, actual %0d", $time, owed.count, count);
        failed = 1'b1;
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [1:0]              cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              req_type_i;
  logic [KeyWidth-1:0]     key_in_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [KeyWidth-1:0]     key_out_o;
  logic [1:0]              status_o;
  logic [CountWidth-1:0]   count_o;

  SortedQueueMirror queue_mirror;

  // Percent of cycles in which each side idles; changed only between phases.
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;

  sorted_priority_queue #(
    .DEPTH    (Depth),
    .KEY_WIDTH(KeyWidth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .key_in_i   (key_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .key_out_o  (key_out_o),
    .status_o   (status_o),
    .count_o    (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one request word and hold it until the block takes it. The task
  // returns in the time step of the accepting edge, so a following call can
  // keep valid high without a gap. Handshake signals are sampled right after
  // the edge, before any nonblocking update of that step lands.
  task automatic send_word(input logic [1:0] req, input logic [KeyWidth-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    key_in_i <= key;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    queue_mirror.note_request(req, key);
  endtask

  // One register write; the mirror follows at the edge that performs it.
  task automatic write_reg(input logic [1:0] index, input logic [CfgDataWidth-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    queue_mirror.write_reg(index, data);
    cfg_we_i <= 1'b0;
  endtask

  // Every request yields a result, so once nothing is owed the block is idle.
  // The short pause covers the output register.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (queue_mirror.pending() > 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  // Half the keys span the whole range so every bit toggles; the rest crowd
  // into a few small values and the extremes so equal keys meet often.
  function automatic logic [KeyWidth-1:0] pick_key();
    int roll;
    roll = $urandom_range(9);
    if (roll < 5) begin
      return KeyWidth'($urandom);
    end
    if (roll < 8) begin
      return KeyWidth'($urandom_range(7));
    end
    return (roll == 8) ? {KeyWidth{1'b0}} : {KeyWidth{1'b1}};
  endfunction

  function automatic logic [1:0] pick_request(burst_e mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      BURST_FILL: begin
        if (roll < 85) return REQ_INSERT;
        return (roll < 95) ? REQ_PEEK : REQ_REMOVE;
      end
      BURST_DRAIN: begin
        if (roll < 80) return REQ_REMOVE;
        return (roll < 95) ? REQ_PEEK : REQ_INSERT;
      end
      BURST_MIXED: begin
        if (roll < 45) return REQ_INSERT;
        if (roll < 80) return REQ_REMOVE;
        return (roll < 95) ? REQ_PEEK : ReqUnused;
      end
      default: begin
        return 2'($urandom_range(3));
      end
    endcase
  endfunction

  // Capacity settings lean on the corners: zero, one, full depth and values
  // past the depth, which the block must saturate.
  function automatic logic [CfgDataWidth-1:0] pick_capacity();
    int roll;
    roll = $urandom_range(9);
    case (roll)
      0: return '0;
      1: return CfgDataWidth'(1);
      2: return '1;
      3: return CfgDataWidth'($urandom_range(Depth + 1, 30));
      4, 5: return CfgDataWidth'(Depth);
      default: return CfgDataWidth'($urandom_range(2, Depth));
    endcase
  endfunction

  // A segment starts from an idle block with fresh register values, then runs
  // bursts that mostly fill, mostly drain, mix, or throw any code at the block.
  // Entries stay stored across the writes, so order flips and capacity drops
  // below the count happen with a populated queue.
  task automatic run_segment(input int words);
    int     sent;
    int     burst_len;
    burst_e mode;
    wait_idle();
    write_reg(CFG_SORT_ORDER, CfgDataWidth'($urandom_range(1)));
    write_reg(CFG_CAPACITY, pick_capacity());
    sent = 0;
    while (sent < words) begin
      mode = burst_e'($urandom_range(3));
      burst_len = $urandom_range(1, 20);
      for (int j = 0; j < burst_len && sent < words; j++) begin
        send_word(pick_request(mode), pick_key());
        sent++;
      end
    end
  endtask

  // Result side: checks each accepted result word and drives out_ready_i.
  // After the 250th and 600th result it holds off for a long stretch, so the
  // output register stays full and the block has to stall its input while
  // the sender keeps offering words.
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        queue_mirror.check_result(key_out_o, status_o, count_o);
        seen++;
        if (seen == 250 || seen == 600) begin
          hold_left = 120;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    queue_mirror = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_SORT_ORDER;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    req_type_i = REQ_INSERT;
    key_in_i = '0;
    send_idle_pct = 24;
    recv_idle_pct = 54;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part, largest key first with the full depth available.
    write_reg(CFG_SORT_ORDER, '0);
    write_reg(CFG_CAPACITY, CfgDataWidth'(Depth));
    // Remove and peek on an empty queue, then the unused code.
    send_word(REQ_REMOVE, 16'h0000);
    send_word(REQ_PEEK, 16'h0000);
    send_word(ReqUnused, 16'hFFFF);
    // Key extremes and a pair of equal keys.
    send_word(REQ_INSERT, 16'h0000);
    send_word(REQ_INSERT, 16'hFFFF);
    send_word(REQ_INSERT, 16'h8000);
    send_word(REQ_INSERT, 16'h8000);
    send_word(REQ_INSERT, 16'h7FFF);
    send_word(REQ_PEEK, 16'h1234);
    send_word(ReqUnused, 16'h5555);
    repeat (6) send_word(REQ_REMOVE, 16'hAAAA);

    // A capacity of zero behaves as one: the second insert is refused.
    wait_idle();
    write_reg(CFG_CAPACITY, '0);
    send_word(REQ_INSERT, 16'h1234);
    send_word(REQ_INSERT, 16'h4321);
    send_word(REQ_PEEK, 16'h0000);

    // Capacity past the depth saturates; fill in smallest-first order.
    wait_idle();
    write_reg(CFG_SORT_ORDER, CfgDataWidth'(1));
    write_reg(CFG_CAPACITY, '1);
    send_word(REQ_INSERT, 16'h0014);
    send_word(REQ_INSERT, 16'h000A);

    // Flip the order with entries stored: they are not re-sorted, and the
    // new insert stops at the first entry it beats under the new rule.
    wait_idle();
    write_reg(CFG_SORT_ORDER, '0);
    send_word(REQ_INSERT, 16'h000F);

    // Capacity dropped below the count refuses inserts but keeps entries.
    wait_idle();
    write_reg(CFG_CAPACITY, CfgDataWidth'(2));
    send_word(REQ_INSERT, 16'h0005);
    send_word(REQ_REMOVE, 16'h0000);

    // Random part in three idling phases of 250 words each.
    repeat (5) run_segment(50);
    wait_idle();
    send_idle_pct = 54;
    recv_idle_pct = 24;
    repeat (5) run_segment(50);
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) run_segment(50);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (queue_mirror.failed) begin
      $display("CHECK FAILED");
    end else begin
      $display("CHECK OK");
    end
    $finish;
  end

endmodule
